>>> rtl/slid_pkg.sv
// Shared types and constants for the sorted key list core.
package slid_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int KEY_W    = 8;
    localparam int STATUS_W = 3;
    localparam int OCOUNT_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming beat
        logic apply;  // update the cells and register the result
    } t_slid_cmd;

endpackage

>>> rtl/slid_ctrl.sv
// Controller state machine: input handshake, sequencing and result valid.
module slid_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output slid_pkg::t_slid_cmd o_cmd
);
    import slid_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.load  = 1'b0;
        o_cmd.apply = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result may only be written once the output slot is free.
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/slid_datapath.sv
// Datapath: row of compare-and-shift key cells, fill count and result register.
module slid_datapath #(
    parameter int CAPACITY = slid_pkg::DEFAULT_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slid_pkg::t_slid_cmd             i_cmd,
    input  logic                            i_command,
    input  logic signed [slid_pkg::KEY_W-1:0] i_key,
    output logic [slid_pkg::STATUS_W-1:0]   o_status,
    output logic [slid_pkg::OCOUNT_W-1:0]   o_entry_count,
    output logic                            o_is_empty
);
    import slid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = CNT_W + OCOUNT_W;

    logic signed [KEY_W-1:0] r_cells [CAPACITY];
    logic                    r_command;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_count, n_count;

    logic [STATUS_W-1:0]     r_status, n_status;
    logic [OCOUNT_W-1:0]     r_entry_count;
    logic                    r_is_empty;

    logic [CAPACITY-1:0]     valid;
    logic [CAPACITY-1:0]     ge;
    logic [CAPACITY-1:0]     eq;
    logic [CAPACITY-1:0]     take;
    logic                    is_full, is_zero, found, do_ins, do_del;
    logic [PAD_W-1:0]        count_pad;

    // Per-cell compares, all independent of each other.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i] = (CNT_W'(i) < r_count);
            ge[i]    = valid[i] && (r_cells[i] >= r_key);
            eq[i]    = valid[i] && (r_cells[i] == r_key);
            // For insert the first empty cell also takes part in the shift.
            take[i]  = valid[i] ? ge[i] : (CNT_W'(i) == r_count);
        end
    end

    assign is_full = (r_count == CNT_W'(CAPACITY));
    assign is_zero = (r_count == '0);
    assign found   = |eq;
    assign do_ins  = i_cmd.apply && (r_command == CMD_INSERT) && !is_full;
    assign do_del  = i_cmd.apply && (r_command == CMD_DELETE) && found;

    always_comb begin
        n_count = r_count;
        if (r_command == CMD_INSERT) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (is_zero) begin
                n_status = ST_EMPTY;
            end else if (found) begin
                n_status = ST_DELETED;
                n_count  = r_count - 1'b1;
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    assign count_pad = {{OCOUNT_W{1'b0}}, n_count};

    // Each cell either keeps its key, takes the new key, or takes a neighbour.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (do_ins && take[g]) begin
                if (g > 0 && take[(g > 0) ? g - 1 : 0]) begin
                    r_cells[g] <= r_cells[(g > 0) ? g - 1 : 0];
                end else begin
                    r_cells[g] <= r_key;
                end
            end else if (do_del && ge[g] && (g < CAPACITY - 1)) begin
                r_cells[g] <= r_cells[(g < CAPACITY - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_key     <= i_key;
        end
        if (i_cmd.apply) begin
            r_status      <= n_status;
            r_entry_count <= count_pad[OCOUNT_W-1:0];
            r_is_empty    <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;

endmodule

>>> rtl/sorted_list_insert_delete_core.sv
// Top level of the sorted key list core: stream ports, controller and datapath.
//
//  Channel   Direction  Signals                         Content
//  -------   ---------  ------------------------------  -------------------------------
//  s_axis    in         tvalid, tready, tdata, tuser    one command beat: key and opcode
//  m_axis    out        tvalid, tready, tdata, tuser    one result beat per command
//
// The beat is captured in the cycle it is accepted, and the whole row of key cells
// compares and shifts in parallel in the execute state that follows, so the work
// per command does not depend on how full the list is.
// Reset is synchronous and active low; it empties the list and clears the result
// valid. Key cells are not cleared, since only cells below the count are ever read.
// A result waiting on m_axis does not stop the next beat being accepted; the
// second command only holds in its execute cycle until the output register frees.
module sorted_list_insert_delete_core #(
    parameter int CAPACITY = slid_pkg::DEFAULT_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Command channel.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] key (signed)
    input  logic       i_s_axis_tuser,   // [0] command: 0 insert, 1 delete
    // Result channel.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [4:0] entry_count, [5] is_empty, [7:6] zero
    output logic [2:0] o_m_axis_tuser    // [2:0] status
);
    import slid_pkg::*;

    t_slid_cmd           cmd;
    logic [OCOUNT_W-1:0] entry_count;
    logic                is_empty;

    // The controller owns the handshakes and decides when the datapath moves.
    slid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    // The datapath holds the keys in ascending order, one per cell, and the
    // registered result of the last command.
    slid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_command     (i_s_axis_tuser),
        .i_key         (i_s_axis_tdata),
        .o_status      (o_m_axis_tuser),
        .o_entry_count (entry_count),
        .o_is_empty    (is_empty)
    );

    assign o_m_axis_tdata = {2'b00, is_empty, entry_count};

endmodule

>>> rtl/slid_checker.sv
// Port-level assertions for the sorted key list core, with their bind.
module slid_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_tvalid,
    input logic       i_in_tready,
    input logic       i_out_tvalid,
    input logic       i_out_tready,
    input logic [7:0] i_out_tdata,
    input logic [2:0] i_out_tuser
);
    import slid_pkg::*;

    // One command is worked on at a time, so ready drops after an accepted beat.
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_tvalid && i_in_tready) |=> !i_in_tready)
        else $error("command accepted while the previous one is in execution");

    // A result is held until taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_tvalid && !i_out_tready) |=>
            (i_out_tvalid && $stable(i_out_tdata) && $stable(i_out_tuser)))
        else $error("result beat changed or dropped while stalled");

    // An empty list always reports a count of zero.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_tvalid && i_out_tdata[5]) |-> (i_out_tdata[4:0] == '0))
        else $error("empty flag set with a non-zero count");

    // After an insert, or an insert refused because the list is full, the list
    // always holds at least one key.
    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_tvalid && (i_out_tuser == ST_FULL || i_out_tuser == ST_INSERTED))
            |-> !i_out_tdata[5])
        else $error("list reported empty after an insert or a full refusal");

endmodule

bind sorted_list_insert_delete_core slid_checker u_slid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_tvalid  (i_s_axis_tvalid),
    .i_in_tready  (o_s_axis_tready),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata),
    .i_out_tuser  (o_m_axis_tuser)
);

>>> tb/tb_sorted_list_insert_delete_core.sv
`timescale 1ns / 1ps
// Testbench for the sorted key list core, checking every result beat against a predicted list.
module tb_sorted_list_insert_delete_core;
    import slid_pkg::*;

    // The list size used both by the core and by the local copy of the list.
    localparam int CAPACITY    = DEFAULT_CAPACITY;
    // Each command spends time in the core, in idle bursts on the sending side
    // and in stall bursts on the receiving side; the limit is set well above
    // what the whole run needs.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last expected beat before the verdict.
    localparam int DRAIN_WAIT  = 8;
    // Beyond this many mismatches the lines are counted but no longer printed.
    localparam int PRINT_LIMIT = 40;

    // One expected result beat, split into its fields.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OCOUNT_W-1:0] count;
        logic                is_empty;
    } t_list_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [KEY_W-1:0]    i_s_axis_tdata;   // [7:0] key (signed)
    logic                i_s_axis_tuser;   // [0] command: 0 insert, 1 delete
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [7:0]          o_m_axis_tdata;   // [4:0] entry_count, [5] is_empty, [7:6] zero
    logic [STATUS_W-1:0] o_m_axis_tuser;   // [2:0] status

    // The keys the core should hold, in ascending order.
    logic signed [KEY_W-1:0] held_keys[$];
    // Results predicted for accepted commands and not yet seen on the output.
    t_list_result            pending_results[$];

    int mismatches  = 0;
    int result_beats = 0;
    int cycle_count = 0;
    // Random idling on the command side and stalling on the result side.
    bit sender_idles   = 1'b1;
    bit receiver_stalls = 1'b1;

    sorted_list_insert_delete_core #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one command to the local list and returns the result the core
    // ought to give for it. An insert goes in front of the first key that is
    // not smaller, so a new duplicate leads its run of equal keys; a delete
    // takes out the first equal key it meets.
    function automatic t_list_result apply_command(input logic cmd,
                                                   input logic signed [KEY_W-1:0] key);
        t_list_result res;
        int           pos;
        pos = 0;
        if (cmd == CMD_INSERT) begin
            if (held_keys.size() >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                while (pos < held_keys.size() && key > held_keys[pos])
                    pos++;
                held_keys.insert(pos, key);
                res.status = ST_INSERTED;
            end
        end else if (held_keys.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            while (pos < held_keys.size() && held_keys[pos] != key)
                pos++;
            if (pos >= held_keys.size()) begin
                res.status = ST_NOT_FOUND;
            end else begin
                held_keys.delete(pos);
                res.status = ST_DELETED;
            end
        end
        // The count port is only five bits wide and wraps for larger lists.
        res.count    = OCOUNT_W'(held_keys.size());
        res.is_empty = (held_keys.size() == 0);
        return res;
    endfunction

    // Chooses a key for the next command. Deletes mostly name a key that is
    // held, so that they find something; inserts mix the whole key range with
    // a narrow band around zero, which builds up runs of duplicates.
    function automatic logic [KEY_W-1:0] pick_key(input logic cmd);
        if (cmd == CMD_DELETE && held_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        if ($urandom_range(0, 1) == 0)
            return KEY_W'($urandom_range(0, 8) - 4);
        return KEY_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch in %s on result beat %0d: got %0d, expected %0d",
                     what, result_beats, got, want);
        mismatches++;
    endtask

    // Sends one command beat, called at a falling edge. An idle burst may come
    // first; the beat is held until the core takes it, and the expected result
    // is worked out at the very edge on which it is accepted.
    task automatic send_command(input logic cmd, input logic [KEY_W-1:0] key);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = key;
        i_s_axis_tuser  = cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        pending_results.push_back(apply_command(cmd, key));
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Holds back further commands until every predicted result has come out,
    // then waits out the drain allowance before returning.
    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Deleting from the empty list, with key zero and the most negative key.
    task automatic test_empty_deletes();
        send_command(CMD_DELETE, 8'h00);
        send_command(CMD_DELETE, 8'h80);
    endtask

    // Both ends of the key range, a duplicate pair, a delete of key zero, a
    // delete of a key that is absent, and removal of the extremes.
    task automatic test_key_extremes();
        send_command(CMD_INSERT, 8'h7f);
        send_command(CMD_INSERT, 8'h80);
        send_command(CMD_INSERT, 8'h00);
        send_command(CMD_INSERT, 8'h00);
        send_command(CMD_INSERT, 8'hff);
        send_command(CMD_INSERT, 8'h01);
        send_command(CMD_DELETE, 8'h00);
        send_command(CMD_DELETE, 8'h05);
        send_command(CMD_DELETE, 8'h80);
        send_command(CMD_DELETE, 8'h7f);
    endtask

    // Fills the list to the brim, tries one insert too many, and then deletes
    // the largest key from the full list.
    task automatic test_full_list();
        while (held_keys.size() < CAPACITY)
            send_command(CMD_INSERT, pick_key(CMD_INSERT));
        send_command(CMD_INSERT, 8'h55);
        send_command(CMD_DELETE, held_keys[held_keys.size() - 1]);
    endtask

    // Random commands in swings between filling and emptying, so that the
    // list keeps passing through every level, including full and empty.
    task automatic test_random_sequences(input int n_items);
        int   sent;
        bit   growing;
        int   insert_share;
        logic cmd;
        sent    = 0;
        growing = 1'b1;
        while (sent < n_items) begin
            if (held_keys.size() >= CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (held_keys.size() == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                growing = !growing;
            insert_share = growing ? 80 : 20;
            cmd = ($urandom_range(0, 99) < insert_share) ? CMD_INSERT : CMD_DELETE;
            send_command(cmd, pick_key(cmd));
            sent++;
        end
    endtask

    // The result side: ready falls for random bursts while stalling is on.
    always begin
        @(negedge i_clk);
        if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            i_m_axis_tready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_m_axis_tready = 1'b1;
    end

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, status", o_m_axis_tuser, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser !== want.status)
                    report_mismatch("status", o_m_axis_tuser, want.status);
                if (o_m_axis_tdata[4:0] !== want.count)
                    report_mismatch("entry_count", o_m_axis_tdata[4:0], want.count);
                if (o_m_axis_tdata[5] !== want.is_empty)
                    report_mismatch("is_empty", o_m_axis_tdata[5], want.is_empty);
            end
            result_beats++;
        end
    end

    // Guards against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_INSERT;
        i_m_axis_tready = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_deletes();
        test_key_extremes();
        test_full_list();
        test_random_sequences(500);
        // Let the core run completely dry once before carrying on.
        wait_for_drain();
        test_random_sequences(500);
        // The closing stretch runs with both sides at full speed.
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        test_random_sequences(200);
        wait_for_drain();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/slid_pkg.sv
rtl/slid_ctrl.sv
rtl/slid_datapath.sv
rtl/sorted_list_insert_delete_core.sv
rtl/slid_checker.sv
tb/tb_sorted_list_insert_delete_core.sv
